[design/tlc_pkg.sv]
`default_nettype none
package tlc_pkg;

    localparam int SUM_W = 63;
    localparam int CNT_W = 16;
    localparam int N_W = 34;
    localparam int M_W = 69;
    localparam int DOT_W = 69;
    localparam int SQ_W = 2 * DOT_W;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef enum logic [2:0] {
        REG_TRK_X   = 3'd0,
        REG_TRK_Y   = 3'd1,
        REG_SLOPE_X = 3'd2,
        REG_SLOPE_Y = 3'd3,
        REG_REF_Z   = 3'd4
    } reg_idx_t;

    // one classified line between front and back
    typedef struct packed {
        logic                   parallel;
        logic [SQ_W-1:0]        dot_sq;
        logic [M_W-1:0]         norm_sq;
        logic                   last;
    } line_job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_ACC,
        BK_OUT
    } back_state_t;

endpackage
`default_nettype wire

[design/track_to_lines_chisq.sv]
`default_nettype none
// squared distance sum of a track to measured lines. a five-stage front end
// forms n = t x l, the dot n.d and |n|^2, then the squared dot from three
// partial products, and passes each line through a two-entry queue to the back
// end, which divides by |n|^2 one quotient bit a cycle and then accumulates
// with saturation. the back end takes no new line until the restoring divider
// and the accumulation are through with the last; parallel lines and terms
// found too large at once skip the divider. the item marked last_line gives one
// result when its own term is in.
module track_to_lines_chisq
    import tlc_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] line_point_x,
    input  wire logic signed [31:0] line_point_y,
    input  wire logic signed [31:0] line_point_z,
    input  wire logic signed [15:0] line_dir_x,
    input  wire logic signed [15:0] line_dir_y,
    input  wire logic signed [15:0] line_dir_z,
    input  wire                     last_line,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [62:0]             chi_square,
    output logic [15:0]             lines_counted,
    output logic                    degenerate_seen,
    output logic                    sum_saturated
);

    logic signed [31:0] trk_x_reg, trk_y_reg, ref_z_reg;
    logic signed [15:0] slope_x_reg, slope_y_reg;

    // track registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_x_reg <= '0;
            trk_y_reg <= '0;
            ref_z_reg <= '0;
            slope_x_reg <= '0;
            slope_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRK_X:   trk_x_reg <= cfg_data;
                REG_TRK_Y:   trk_y_reg <= cfg_data;
                REG_SLOPE_X: slope_x_reg <= cfg_data[15:0];
                REG_SLOPE_Y: slope_y_reg <= cfg_data[15:0];
                REG_REF_Z:   ref_z_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    logic      f_valid, f_ready, q_valid, q_ready;
    line_job_t f_job, q_job;

    tlc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .trk_x(trk_x_reg), .trk_y(trk_y_reg), .trk_z(ref_z_reg),
        .slope_x(slope_x_reg), .slope_y(slope_y_reg),
        .in_valid(in_valid), .in_ready(in_ready),
        .px(line_point_x), .py(line_point_y), .pz(line_point_z),
        .lx(line_dir_x), .ly(line_dir_y), .lz(line_dir_z), .last(last_line),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    tlc_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    tlc_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .out_valid(out_valid), .out_ready(out_ready),
        .sum(chi_square), .count(lines_counted),
        .degen(degenerate_seen), .sat(sum_saturated)
    );

    // a result with no line counted carries neither a sum nor a clip
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lines_counted == '0 |-> chi_square == '0 && !sum_saturated)
        else $error("empty set with a sum");

    // a result never appears without the queue having delivered a line before
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(q_ready))
        else $error("result without line");

endmodule
`default_nettype wire

[design/tlc_front.sv]
`default_nettype none
module tlc_front
    import tlc_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire logic signed [31:0] trk_x,
    input  wire logic signed [31:0] trk_y,
    input  wire logic signed [31:0] trk_z,
    input  wire logic signed [15:0] slope_x,
    input  wire logic signed [15:0] slope_y,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire logic signed [31:0] px,
    input  wire logic signed [31:0] py,
    input  wire logic signed [31:0] pz,
    input  wire logic signed [15:0] lx,
    input  wire logic signed [15:0] ly,
    input  wire logic signed [15:0] lz,
    input  wire                    last,
    output logic                   job_valid,
    input  wire                    job_ready,
    output line_job_t              job
);

    // stage 1: cross product and differences
    logic                   s1_v_reg;
    logic signed [N_W-1:0]  nx_reg, ny_reg, nz_reg;
    logic signed [32:0]     dx_reg, dy_reg, dz_reg;
    logic                   s1_last_reg;
    // stage 2: products
    logic                   s2_v_reg;
    logic signed [67:0]     px_reg, py_reg, pz_reg;
    logic [M_W-1:0]         m_reg;
    logic                   s2_last_reg;
    // stage 3: dot and magnitude
    logic                   s3_v_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [M_W-1:0]         m3_reg;
    logic                   s3_last_reg;
    // stage 4: partial squares of |n.d|, split at bit 32
    logic                   s4_v_reg;
    logic [65:0]            pp_hh_reg;
    logic [64:0]            pp_hl_reg;
    logic [63:0]            pp_ll_reg;
    logic [M_W-1:0]         m4_reg;
    logic                   s4_last_reg;
    // stage 5: squared dot
    logic                   s5_v_reg;
    line_job_t              s5_reg;

    logic adv;
    logic [64:0] dot_abs;

    assign adv      = !s5_v_reg || job_ready;
    assign in_ready = adv;
    assign job_valid = s5_v_reg;
    assign job = s5_reg;
    // |n.d| stays below 2^65
    assign dot_abs = 65'(dot_reg[DOT_W-1] ? -dot_reg : dot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg <= N_W'(slope_y * lz) - N_W'(ONE_Q14 * ly);
            ny_reg <= N_W'(ONE_Q14 * lx) - N_W'(slope_x * lz);
            nz_reg <= N_W'(slope_x * ly) - N_W'(slope_y * lx);
            dx_reg <= 33'(trk_x) - 33'(px);
            dy_reg <= 33'(trk_y) - 33'(py);
            dz_reg <= 33'(trk_z) - 33'(pz);
            s1_last_reg <= last;
            px_reg <= 68'(nx_reg) * 68'(dx_reg);
            py_reg <= 68'(ny_reg) * 68'(dy_reg);
            pz_reg <= 68'(nz_reg) * 68'(dz_reg);
            m_reg <= M_W'(68'(nx_reg) * 68'(nx_reg)) + M_W'(68'(ny_reg) * 68'(ny_reg))
                   + M_W'(68'(nz_reg) * 68'(nz_reg));
            s2_last_reg <= s1_last_reg;
            dot_reg <= DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
            m3_reg <= m_reg;
            s3_last_reg <= s2_last_reg;
            pp_hh_reg <= 66'(dot_abs[64:32]) * 66'(dot_abs[64:32]);
            pp_hl_reg <= 65'(dot_abs[64:32]) * 65'(dot_abs[31:0]);
            pp_ll_reg <= 64'(dot_abs[31:0]) * 64'(dot_abs[31:0]);
            m4_reg <= m3_reg;
            s4_last_reg <= s3_last_reg;
            s5_reg.parallel <= (m4_reg == '0);
            s5_reg.dot_sq <= SQ_W'({pp_hh_reg, 64'd0}) + SQ_W'({pp_hl_reg, 33'd0})
                           + SQ_W'(pp_ll_reg);
            s5_reg.norm_sq <= m4_reg;
            s5_reg.last <= s4_last_reg;
        end
    end

endmodule
`default_nettype wire

[design/tlc_fifo.sv]
`default_nettype none
module tlc_fifo
    import tlc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        wr_valid,
    output logic       wr_ready,
    input  line_job_t  wr_data,
    output logic       rd_valid,
    input  wire        rd_ready,
    output line_job_t  rd_data
);

    line_job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule
`default_nettype wire

[design/tlc_back.sv]
`default_nettype none
module tlc_back
    import tlc_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              job_valid,
    output logic             job_ready,
    input  line_job_t        job,
    output logic             out_valid,
    input  wire              out_ready,
    output logic [SUM_W-1:0] sum,
    output logic [CNT_W-1:0] count,
    output logic             degen,
    output logic             sat
);

    back_state_t state_reg, state_next;
    logic [SQ_W-1:0]  num_reg;
    logic [M_W:0]     rem_reg;
    logic [M_W-1:0]   den_reg;
    logic [7:0]       step_reg;
    logic             last_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             par_reg, sat_reg;
    logic [SUM_W-1:0] osum_reg;
    logic [CNT_W-1:0] ocnt_reg;
    logic             opar_reg, osat_reg;

    logic [M_W:0]     trial;
    logic             ge;
    logic [SUM_W:0]   added;
    logic             take;
    logic             q_big;
    logic             emit;

    assign trial = {rem_reg[M_W-1:0], num_reg[SQ_W-1]};
    assign ge = trial >= {1'b0, den_reg};
    assign added = {1'b0, acc_reg} + {1'b0, num_reg[SUM_W-1:0]};
    assign take = job_valid && job_ready;
    // quotient of 2^63 or more
    assign q_big = |num_reg[SQ_W-M_W-1:SUM_W];
    assign emit = (state_reg == BK_OUT) && (!out_valid || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (job_valid)
                    state_next = (job.parallel || job.dot_sq[SQ_W-1:SQ_W-M_W] >= job.norm_sq)
                               ? (job.last ? BK_OUT : BK_IDLE) : BK_DIV;
            BK_DIV:
                if (step_reg == 8'(SQ_W - M_W - 1))
                    state_next = BK_ACC;
            BK_ACC:
                state_next = last_reg ? BK_OUT : BK_IDLE;
            BK_OUT:
                if (!out_valid || out_ready)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        job_ready = (state_reg == BK_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            acc_reg <= '0;
            cnt_reg <= '0;
            par_reg <= 1'b0;
            sat_reg <= 1'b0;
            out_valid <= 1'b0;
            step_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                BK_IDLE:
                    if (take)
                    begin
                        last_reg <= job.last;
                        step_reg <= '0;
                        if (job.parallel)
                            par_reg <= 1'b1;
                        else
                        begin
                            if (cnt_reg != CNT_MAX)
                                cnt_reg <= cnt_reg + 1'b1;
                            if (job.dot_sq[SQ_W-1:SQ_W-M_W] >= job.norm_sq)
                            begin
                                acc_reg <= SUM_MAX;
                                sat_reg <= 1'b1;
                            end
                        end
                    end
                BK_DIV:
                    step_reg <= step_reg + 1'b1;
                BK_ACC:
                    if (q_big || added[SUM_W])
                    begin
                        acc_reg <= SUM_MAX;
                        sat_reg <= 1'b1;
                    end
                    else
                        acc_reg <= added[SUM_W-1:0];
                BK_OUT:
                    if (emit)
                    begin
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        par_reg <= 1'b0;
                        sat_reg <= 1'b0;
                    end
                default:
                    ;
            endcase
        end
    end

    // restoring division; quotient bits shift into the low end of num_reg
    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && take)
        begin
            rem_reg <= {1'b0, job.dot_sq[SQ_W-1:SQ_W-M_W]};
            num_reg <= {job.dot_sq[SQ_W-M_W-1:0], {M_W{1'b0}}};
            den_reg <= job.norm_sq;
        end
        else if (state_reg == BK_DIV)
        begin
            rem_reg <= ge ? trial - {1'b0, den_reg} : trial;
            num_reg <= {num_reg[SQ_W-2:0], ge};
        end
        if (emit)
        begin
            osum_reg <= acc_reg;
            ocnt_reg <= cnt_reg;
            opar_reg <= par_reg;
            osat_reg <= sat_reg;
        end
    end

    assign sum = osum_reg;
    assign count = ocnt_reg;
    assign degen = opar_reg;
    assign sat = osat_reg;

endmodule
`default_nettype wire
